// ===== design/arxps_pkg.sv =====
// arxps_pkg: shared types and constants of the arx keystream phase scrambler
// seed words, fixed-point constants, state types and the queue status group
// no dependencies
package arxps_pkg;

    // seed words of the quarter-round state (ASCII "expand 332 yte k", little-endian)
    localparam logic [31:0] SEED_A = 32'h6170_7865;
    localparam logic [31:0] SEED_B = 32'h3320_646e;
    localparam logic [31:0] SEED_C = 32'h7920_3233;
    localparam logic [31:0] SEED_D = 32'h6b20_6574;

    // pi in Q30, so that a 2^-32 turn residual times this over 2^29 is radians in Q32
    localparam logic [31:0] PI_Q30  = 32'hC90F_DAA2;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // entries of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HALF1,
        F_HALF2,
        F_PUSH
    } t_front_state;

    typedef enum logic [5:0] {
        B_IDLE,
        B_ABS,
        B_MX,
        B_WX,
        B_MX2,
        B_WX2,
        B_MD30,
        B_WD30,
        B_MT1,
        B_WT1,
        B_MD12,
        B_WD12,
        B_MT2,
        B_WT2,
        B_MD42,
        B_WD42,
        B_MS1,
        B_WS1,
        B_MD20,
        B_WD20,
        B_MS2,
        B_WS2,
        B_MD6,
        B_WD6,
        B_MS3,
        B_WS3,
        B_ROT,
        B_MP1,
        B_WP1,
        B_MP2,
        B_WP2,
        B_MP3,
        B_WP3,
        B_MP4,
        B_WP4,
        B_DONE
    } t_back_state;

endpackage

// ===== design/arx_keystream_phase_scrambler_top.sv =====
// path of a word: front round steps, queue, back end states, output register
// the back end sets the word rate, sequencing its single
//   34x34 multiplier through the sine/cosine polynomials and four rotation products
// the front takes new words while the back works, if the 2-entry queue has room
// reset (synchronous, active low): keystream words back to seeds, decrypt to 0,
//   queue and output register empty; no clearing pass
module arx_keystream_phase_scrambler_top #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int PHASE_BITS   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input words
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_q,
    input  logic                           i_restart,
    // output words
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_i,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_q,
    // configuration write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_decrypt
);

    // queue entry: sample i, sample q, top phase bits of the new first word
    localparam int ENTRY_W = 2 * SAMPLE_WIDTH + PHASE_BITS;

    logic r_decrypt;

    logic                    push, pop;
    logic [ENTRY_W-1:0]      push_data, pop_data;
    arxps_pkg::t_fifo_status fifo_status;

    // decrypt reg, always ready; user writes only while block is idle, not checked
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_decrypt <= i_cfg_decrypt;
        end
    end

    // front: handshake and keystream, half a quarter round per cycle
    arxps_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PHASE_BITS   (PHASE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample_i    (i_sample_i),
        .i_sample_q    (i_sample_q),
        .i_restart     (i_restart),
        .i_fifo_status (fifo_status),
        .o_push        (push),
        .o_push_data   (push_data)
    );

    // decouples the keystream from the arithmetic
    arxps_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (fifo_status)
    );

    // back: sine/cosine, rotation, rounding and output register
    arxps_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PHASE_BITS   (PHASE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_decrypt     (r_decrypt),
        .i_fifo_status (fifo_status),
        .o_pop         (pop),
        .i_pop_data    (pop_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_i       (o_out_i),
        .o_out_q       (o_out_q)
    );

endmodule

// ===== design/arxps_front.sv =====
// arxps_front: accepts sample words, advances the quarter-round keystream
// and queues the sample with its phase; uses arxps_pkg
module arxps_front #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int PHASE_BITS   = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_sample_q,
    input  logic                                    i_restart,
    input  arxps_pkg::t_fifo_status                 i_fifo_status,
    output logic                                    o_push,
    output logic [2*SAMPLE_WIDTH+PHASE_BITS-1:0]    o_push_data
);

    arxps_pkg::t_front_state r_state, n_state;

    logic [31:0] r_word_a, r_word_b, r_word_c, r_word_d;
    logic signed [SAMPLE_WIDTH-1:0] r_si, r_sq;
    logic                           r_restart;
    logic [PHASE_BITS-1:0]          r_phase;

    logic        accept;
    logic [31:0] src_a, src_b, src_c, src_d;
    logic [31:0] h1_a, h1_dx, h1_d, h1_c, h1_bx, h1_b;
    logic [31:0] h2_a, h2_dx, h2_d, h2_c, h2_bx, h2_b;

    assign accept = i_in_valid & o_in_ready;

    // first half of the quarter round, from the seeds on restart
    always_comb begin
        src_a = r_restart ? arxps_pkg::SEED_A : r_word_a;
        src_b = r_restart ? arxps_pkg::SEED_B : r_word_b;
        src_c = r_restart ? arxps_pkg::SEED_C : r_word_c;
        src_d = r_restart ? arxps_pkg::SEED_D : r_word_d;
        h1_a  = src_a + src_b;
        h1_dx = src_d ^ h1_a;
        h1_d  = {h1_dx[15:0], h1_dx[31:16]};
        h1_c  = src_c + h1_d;
        h1_bx = src_b ^ h1_c;
        h1_b  = {h1_bx[19:0], h1_bx[31:20]};
    end

    // second half
    always_comb begin
        h2_a  = r_word_a + r_word_b;
        h2_dx = r_word_d ^ h2_a;
        h2_d  = {h2_dx[23:0], h2_dx[31:24]};
        h2_c  = r_word_c + h2_d;
        h2_bx = r_word_b ^ h2_c;
        h2_b  = {h2_bx[24:0], h2_bx[31:25]};
    end

    always_comb begin
        case (r_state)
            arxps_pkg::F_IDLE:  n_state = accept ? arxps_pkg::F_HALF1 : arxps_pkg::F_IDLE;
            arxps_pkg::F_HALF1: n_state = arxps_pkg::F_HALF2;
            arxps_pkg::F_HALF2: n_state = arxps_pkg::F_PUSH;
            arxps_pkg::F_PUSH:  n_state = i_fifo_status.full ? arxps_pkg::F_PUSH
                                                              : arxps_pkg::F_IDLE;
            default:            n_state = arxps_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == arxps_pkg::F_IDLE);
        o_push      = (r_state == arxps_pkg::F_PUSH) && !i_fifo_status.full;
        o_push_data = {r_si, r_sq, r_phase};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= arxps_pkg::F_IDLE;
            r_word_a <= arxps_pkg::SEED_A;
            r_word_b <= arxps_pkg::SEED_B;
            r_word_c <= arxps_pkg::SEED_C;
            r_word_d <= arxps_pkg::SEED_D;
        end else begin
            r_state <= n_state;
            case (r_state)
                arxps_pkg::F_HALF1: begin
                    r_word_a <= h1_a;
                    r_word_b <= h1_b;
                    r_word_c <= h1_c;
                    r_word_d <= h1_d;
                end
                arxps_pkg::F_HALF2: begin
                    r_word_a <= h2_a;
                    r_word_b <= h2_b;
                    r_word_c <= h2_c;
                    r_word_d <= h2_d;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_si      <= i_sample_i;
            r_sq      <= i_sample_q;
            r_restart <= i_restart;
        end
        if (r_state == arxps_pkg::F_HALF2) begin
            r_phase <= h2_a[31 -: PHASE_BITS];
        end
    end

    // keystream only moves in the two round steps
    a_words_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == arxps_pkg::F_IDLE || r_state == arxps_pkg::F_PUSH)
            |=> $stable(r_word_a) && $stable(r_word_d))
        else $error("keystream words changed outside a round step");

endmodule

// ===== design/arxps_fifo.sv =====
// arxps_fifo: short register queue between front and back
// depth from arxps_pkg::QUEUE_DEPTH; uses arxps_pkg
module arxps_fifo #(
    parameter int WIDTH = 48
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [WIDTH-1:0]        i_push_data,
    input  logic                    i_pop,
    output logic [WIDTH-1:0]        o_pop_data,
    output arxps_pkg::t_fifo_status o_status
);

    localparam int DEPTH = arxps_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data     = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");

endmodule

// ===== design/arxps_back.sv =====
// arxps_back: phase to sine/cosine by polynomial on one shared multiplier,
// then complex rotation, rounding and the output register; uses arxps_pkg
module arxps_back #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int PHASE_BITS   = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_decrypt,
    input  arxps_pkg::t_fifo_status                 i_fifo_status,
    output logic                                    o_pop,
    input  logic [2*SAMPLE_WIDTH+PHASE_BITS-1:0]    i_pop_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]          o_out_i,
    output logic signed [SAMPLE_WIDTH-1:0]          o_out_q
);

    // divide by constant: floor(v * floor(2^K/D) / 2^K), then one correction
    localparam int unsigned D30 = 30;
    localparam int unsigned D12 = 12;
    localparam int unsigned D42 = 42;
    localparam int unsigned D20 = 20;
    localparam int unsigned D6  = 6;
    localparam int unsigned K30 = 37;
    localparam int unsigned K12 = 36;
    localparam int unsigned K42 = 38;
    localparam int unsigned K20 = 37;
    localparam int unsigned K6  = 35;
    localparam logic [32:0] M30 = 33'((65'd1 << K30) / 65'(D30));
    localparam logic [32:0] M12 = 33'((65'd1 << K12) / 65'(D12));
    localparam logic [32:0] M42 = 33'((65'd1 << K42) / 65'(D42));
    localparam logic [32:0] M20 = 33'((65'd1 << K20) / 65'(D20));
    localparam logic [32:0] M6  = 33'((65'd1 << K6) / 65'(D6));

    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic signed [33:0] SAT_HI =
        34'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

    arxps_pkg::t_back_state r_state, n_state;

    logic signed [SAMPLE_WIDTH-1:0] r_si, r_sq;
    logic [31:0]        r_u;
    logic [1:0]         r_quad;
    logic               r_neg;
    logic [29:0]        r_absr;
    logic [31:0]        r_x, r_x2, r_v;
    logic [32:0]        r_t, r_s;
    logic signed [31:0] r_cos, r_sin;
    logic signed [63:0] r_acc_i, r_acc_q;
    logic signed [67:0] r_prod;
    logic               r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_i, r_out_q;

    logic signed [SAMPLE_WIDTH-1:0] ent_si, ent_sq;
    logic [PHASE_BITS-1:0]          ent_ph;
    logic [31:0]        ph_p, ph_pn, ph_u;
    logic signed [33:0] mul_a, mul_b;
    logic signed [33:0] si_ext, sq_ext, cos_ext, sin_ext;
    logic [31:0]        q0, q_div;
    logic [7:0]         div_d, rem8;
    logic [32:0]        div_res;
    logic [32:0]        t_p2, s_p2;
    logic signed [31:0] c0, s0, n_cos, n_sin;
    logic               out_free, out_load;

    function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
        input logic signed [63:0] v
    );
        logic signed [63:0] biased;
        logic signed [33:0] rnd;
        biased = v + 64'sd536870912;
        rnd    = 34'(biased >>> 30);
        if (rnd > SAT_HI) begin
            rnd = SAT_HI;
        end else if (rnd < SAT_LO) begin
            rnd = SAT_LO;
        end
        round_sat = SAMPLE_WIDTH'(rnd);
    endfunction

    // queue entry and phase word
    always_comb begin
        ent_si = i_pop_data[2*SAMPLE_WIDTH+PHASE_BITS-1 -: SAMPLE_WIDTH];
        ent_sq = i_pop_data[SAMPLE_WIDTH+PHASE_BITS-1 -: SAMPLE_WIDTH];
        ent_ph = i_pop_data[PHASE_BITS-1:0];
        ph_p   = 32'(ent_ph) << (32 - PHASE_BITS);
        ph_pn  = i_decrypt ? (32'd0 - ph_p) : ph_p;
        ph_u   = ph_pn + 32'h2000_0000;
    end

    always_comb begin
        si_ext  = {{(34-SAMPLE_WIDTH){r_si[SAMPLE_WIDTH-1]}}, r_si};
        sq_ext  = {{(34-SAMPLE_WIDTH){r_sq[SAMPLE_WIDTH-1]}}, r_sq};
        cos_ext = {{2{r_cos[31]}}, r_cos};
        sin_ext = {{2{r_sin[31]}}, r_sin};
    end

    // shared multiplier operands
    always_comb begin
        case (r_state)
            arxps_pkg::B_MX: begin
                mul_a = {4'b0, r_absr};
                mul_b = {2'b0, arxps_pkg::PI_Q30};
            end
            arxps_pkg::B_MX2: begin
                mul_a = {2'b0, r_x};
                mul_b = {2'b0, r_x};
            end
            arxps_pkg::B_MD30: begin
                mul_a = {2'b0, r_v};
                mul_b = {1'b0, M30};
            end
            arxps_pkg::B_MD12: begin
                mul_a = {2'b0, r_v};
                mul_b = {1'b0, M12};
            end
            arxps_pkg::B_MD42: begin
                mul_a = {2'b0, r_v};
                mul_b = {1'b0, M42};
            end
            arxps_pkg::B_MD20: begin
                mul_a = {2'b0, r_v};
                mul_b = {1'b0, M20};
            end
            arxps_pkg::B_MD6: begin
                mul_a = {2'b0, r_v};
                mul_b = {1'b0, M6};
            end
            arxps_pkg::B_MT1, arxps_pkg::B_MT2: begin
                mul_a = {2'b0, r_x2};
                mul_b = {1'b0, r_t};
            end
            arxps_pkg::B_MS1, arxps_pkg::B_MS2: begin
                mul_a = {2'b0, r_x2};
                mul_b = {1'b0, r_s};
            end
            arxps_pkg::B_MS3: begin
                mul_a = {2'b0, r_x};
                mul_b = {1'b0, r_s};
            end
            arxps_pkg::B_MP1: begin
                mul_a = si_ext;
                mul_b = cos_ext;
            end
            arxps_pkg::B_MP2: begin
                mul_a = sq_ext;
                mul_b = sin_ext;
            end
            arxps_pkg::B_MP3: begin
                mul_a = si_ext;
                mul_b = sin_ext;
            end
            arxps_pkg::B_MP4: begin
                mul_a = sq_ext;
                mul_b = cos_ext;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // quotient estimate is low by at most one; the remainder fits in 8 bits
    always_comb begin
        case (r_state)
            arxps_pkg::B_WD12: begin
                q0    = 32'(r_prod >> K12);
                div_d = 8'(D12);
            end
            arxps_pkg::B_WD42: begin
                q0    = 32'(r_prod >> K42);
                div_d = 8'(D42);
            end
            arxps_pkg::B_WD20: begin
                q0    = 32'(r_prod >> K20);
                div_d = 8'(D20);
            end
            arxps_pkg::B_WD6: begin
                q0    = 32'(r_prod >> K6);
                div_d = 8'(D6);
            end
            default: begin
                q0    = 32'(r_prod >> K30);
                div_d = 8'(D30);
            end
        endcase
        rem8    = r_v[7:0] - 8'(q0[7:0] * div_d);
        q_div   = q0 + 32'(rem8 >= div_d);
        div_res = arxps_pkg::ONE_Q32 - {1'b0, q_div};
    end

    // round to Q30, sign of the residual, then quarter-turn rotation
    always_comb begin
        t_p2 = r_t + 33'd2;
        s_p2 = r_s + 33'd2;
        c0   = {1'b0, t_p2[32:2]};
        s0   = r_neg ? -$signed({1'b0, s_p2[32:2]}) : $signed({1'b0, s_p2[32:2]});
        case (r_quad)
            QUAD_1: begin
                n_cos = -s0;
                n_sin = c0;
            end
            QUAD_2: begin
                n_cos = -c0;
                n_sin = -s0;
            end
            QUAD_3: begin
                n_cos = s0;
                n_sin = -c0;
            end
            default: begin
                n_cos = c0;
                n_sin = s0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            arxps_pkg::B_IDLE: n_state = i_fifo_status.empty ? arxps_pkg::B_IDLE
                                                             : arxps_pkg::B_ABS;
            arxps_pkg::B_ABS:  n_state = arxps_pkg::B_MX;
            arxps_pkg::B_MX:   n_state = arxps_pkg::B_WX;
            arxps_pkg::B_WX:   n_state = arxps_pkg::B_MX2;
            arxps_pkg::B_MX2:  n_state = arxps_pkg::B_WX2;
            arxps_pkg::B_WX2:  n_state = arxps_pkg::B_MD30;
            arxps_pkg::B_MD30: n_state = arxps_pkg::B_WD30;
            arxps_pkg::B_WD30: n_state = arxps_pkg::B_MT1;
            arxps_pkg::B_MT1:  n_state = arxps_pkg::B_WT1;
            arxps_pkg::B_WT1:  n_state = arxps_pkg::B_MD12;
            arxps_pkg::B_MD12: n_state = arxps_pkg::B_WD12;
            arxps_pkg::B_WD12: n_state = arxps_pkg::B_MT2;
            arxps_pkg::B_MT2:  n_state = arxps_pkg::B_WT2;
            arxps_pkg::B_WT2:  n_state = arxps_pkg::B_MD42;
            arxps_pkg::B_MD42: n_state = arxps_pkg::B_WD42;
            arxps_pkg::B_WD42: n_state = arxps_pkg::B_MS1;
            arxps_pkg::B_MS1:  n_state = arxps_pkg::B_WS1;
            arxps_pkg::B_WS1:  n_state = arxps_pkg::B_MD20;
            arxps_pkg::B_MD20: n_state = arxps_pkg::B_WD20;
            arxps_pkg::B_WD20: n_state = arxps_pkg::B_MS2;
            arxps_pkg::B_MS2:  n_state = arxps_pkg::B_WS2;
            arxps_pkg::B_WS2:  n_state = arxps_pkg::B_MD6;
            arxps_pkg::B_MD6:  n_state = arxps_pkg::B_WD6;
            arxps_pkg::B_WD6:  n_state = arxps_pkg::B_MS3;
            arxps_pkg::B_MS3:  n_state = arxps_pkg::B_WS3;
            arxps_pkg::B_WS3:  n_state = arxps_pkg::B_ROT;
            arxps_pkg::B_ROT:  n_state = arxps_pkg::B_MP1;
            arxps_pkg::B_MP1:  n_state = arxps_pkg::B_WP1;
            arxps_pkg::B_WP1:  n_state = arxps_pkg::B_MP2;
            arxps_pkg::B_MP2:  n_state = arxps_pkg::B_WP2;
            arxps_pkg::B_WP2:  n_state = arxps_pkg::B_MP3;
            arxps_pkg::B_MP3:  n_state = arxps_pkg::B_WP3;
            arxps_pkg::B_WP3:  n_state = arxps_pkg::B_MP4;
            arxps_pkg::B_MP4:  n_state = arxps_pkg::B_WP4;
            arxps_pkg::B_WP4:  n_state = arxps_pkg::B_DONE;
            arxps_pkg::B_DONE: n_state = out_free ? arxps_pkg::B_IDLE : arxps_pkg::B_DONE;
            default:           n_state = arxps_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        out_free = !r_out_valid || i_out_ready;
        o_pop    = (r_state == arxps_pkg::B_IDLE) && !i_fifo_status.empty;
        out_load = (r_state == arxps_pkg::B_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arxps_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            arxps_pkg::B_IDLE: begin
                if (o_pop) begin
                    r_si <= ent_si;
                    r_sq <= ent_sq;
                    r_u  <= ph_u;
                end
            end
            arxps_pkg::B_ABS: begin
                r_quad <= r_u[31:30];
                r_neg  <= ~r_u[29];
                r_absr <= r_u[29] ? {1'b0, r_u[28:0]}
                                  : 30'h2000_0000 - {1'b0, r_u[28:0]};
            end
            arxps_pkg::B_WX: r_x <= r_prod[60:29];
            arxps_pkg::B_WX2: begin
                r_x2 <= r_prod[63:32];
                r_v  <= r_prod[63:32];
            end
            arxps_pkg::B_WD30, arxps_pkg::B_WD12: r_t <= div_res;
            arxps_pkg::B_WT1: r_v <= r_prod[63:32];
            arxps_pkg::B_WT2: begin
                r_t <= arxps_pkg::ONE_Q32 - {2'b0, r_prod[63:33]};
                r_v <= r_x2;
            end
            arxps_pkg::B_WD42, arxps_pkg::B_WD20, arxps_pkg::B_WD6: r_s <= div_res;
            arxps_pkg::B_WS1, arxps_pkg::B_WS2: r_v <= r_prod[63:32];
            arxps_pkg::B_WS3: r_s <= {1'b0, r_prod[63:32]};
            arxps_pkg::B_ROT: begin
                r_cos <= n_cos;
                r_sin <= n_sin;
            end
            arxps_pkg::B_WP1: r_acc_i <= $signed(r_prod[63:0]);
            arxps_pkg::B_WP2: r_acc_i <= r_acc_i - $signed(r_prod[63:0]);
            arxps_pkg::B_WP3: r_acc_q <= $signed(r_prod[63:0]);
            arxps_pkg::B_WP4: r_acc_q <= r_acc_q + $signed(r_prod[63:0]);
            default: ;
        endcase
        if (out_load) begin
            r_out_i <= round_sat(r_acc_i);
            r_out_q <= round_sat(r_acc_q);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_i     = r_out_i;
    assign o_out_q     = r_out_q;

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == arxps_pkg::B_DONE)
        else $error("output word raised outside the done step");

endmodule
